FILE: design/bpsf_pkg.sv
`timescale 1ns / 1ps

package bpsf_pkg;

	// Field widths of the segment and result channels.
	localparam int unsigned ADDR_W     = 64;
	localparam int unsigned SEG_LEN_W  = 32;
	localparam int unsigned SIZE_W     = 64;
	localparam int unsigned OFFSET_W   = 12;
	localparam int unsigned SHIFT_W    = 6;

	// Configuration port geometry: six registers on 8-byte strides.
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_ADDR_W = 6;
	localparam int unsigned CFG_IDX_W  = 3;

	// Defaults for the top-level parameters.
	localparam int unsigned ADDR_BITS_DEF = 64;
	localparam int unsigned PAGE_BITS_DEF = 12;

	localparam logic [63:0] ALL_ONES = '1;

	// Register map indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_SIZE_MASK    = 3'd0,
		REG_VIRT_BASE         = 3'd1,
		REG_REGION_LENGTH     = 3'd2,
		REG_START_PAGE_OFFSET = 3'd3,
		REG_ODP_MODE          = 3'd4,
		REG_ODP_PAGE_SHIFT    = 3'd5
	} cfg_reg_t;

	// Sets every bit at or below the highest set bit of x.
	function automatic logic [63:0] smear_right(input logic [63:0] x);
		logic [63:0] s;
		s = x;
		s = s | (s >> 1);
		s = s | (s >> 2);
		s = s | (s >> 4);
		s = s | (s >> 8);
		s = s | (s >> 16);
		s = s | (s >> 32);
		return s;
	endfunction

	// Keeps only the highest set bit of x.
	function automatic logic [63:0] top_bit(input logic [63:0] x);
		logic [63:0] s;
		s = smear_right(x);
		return s & ~(s >> 1);
	endfunction

endpackage

FILE: design/bpsf_if.sv
`timescale 1ns / 1ps

// Segment channel: one beat per DMA segment.
interface bpsf_seg_if;
	logic                           valid;
	logic                           ready;
	logic [bpsf_pkg::ADDR_W-1:0]    seg_address;
	logic [bpsf_pkg::SEG_LEN_W-1:0] seg_length;
	logic                           seg_last;

	modport source (output valid, seg_address, seg_length, seg_last, input ready);
	modport sink   (input valid, seg_address, seg_length, seg_last, output ready);
endinterface

// Result channel: one beat per region.
interface bpsf_res_if;
	logic                        valid;
	logic                        ready;
	logic [bpsf_pkg::SIZE_W-1:0] best_page_size;

	modport source (output valid, best_page_size, input ready);
	modport sink   (input valid, best_page_size, output ready);
endinterface

FILE: design/best_page_size_finder_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat                                   Handshake
// seg       in   seg_address, seg_length, seg_last      valid / ready
// res       out  best_page_size (one per last segment)  valid / ready
// cfg       in   APB write/read, six 64-bit registers   psel / penable / pready
//
// One segment is accepted per cycle, except while a last segment in the input
// register waits for room in the mask stage. A segment sits in the input
// register, where the running state is updated; a last segment then moves to
// the mask register and on to the output register, which presents its result.
// Reset clears all control and running state. A stalled result holds
// only the stages behind it that are full, so segments keep flowing while the
// output and mask stages have room.

module best_page_size_finder_top #(
	parameter int unsigned ADDR_BITS = bpsf_pkg::ADDR_BITS_DEF,
	parameter int unsigned PAGE_BITS = bpsf_pkg::PAGE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bpsf_seg_if.sink                         seg,
	bpsf_res_if.source                       res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bpsf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [bpsf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [bpsf_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import bpsf_pkg::*;

	localparam logic [63:0] ADDR_MASK     = ALL_ONES >> (64 - ADDR_BITS);
	localparam logic [63:0] PAGE_OFF_MASK = ALL_ONES >> (64 - PAGE_BITS);

	// Configuration registers.
	logic [63:0]         psm_q;
	logic [63:0]         virt_base_q;
	logic [63:0]         region_length_q;
	logic [OFFSET_W-1:0] spo_q;
	logic                odp_mode_q;
	logic [SHIFT_W-1:0]  odp_shift_q;

	// Running region state.
	logic [63:0] diff_mask_q;
	logic [63:0] run_base_q;
	logic [63:0] run_length_q;
	logic [63:0] virt_cursor_q;
	logic        seen_first_q;

	// Input stage.
	logic                 vld_s1;
	logic [63:0]          addr_s1;
	logic [SEG_LEN_W-1:0] len_s1;
	logic                 last_s1;

	// Mask stage and output register.
	logic        vld_s2;
	logic [63:0] diff_s2;
	logic        res_vld_q;
	logic [63:0] res_size_q;

	logic        cfg_wr;
	cfg_reg_t    cfg_idx;
	logic        out_en;
	logic        s2_en;
	logic        s1_go;

	logic        first;
	logic [63:0] span;
	logic [63:0] seed;
	logic [63:0] offset;
	logic [64:0] end_sum;
	logic        ovf;
	logic        restart;
	logic [63:0] diff_base;
	logic [63:0] diff_new;
	logic [63:0] cursor_cur;
	logic [63:0] cursor_next;
	logic [63:0] len64;
	logic [63:0] run_length_next;

	logic [63:0] keep;
	logic [63:0] odp_size;
	logic [63:0] result;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psm_q           <= 64'd4096;
			virt_base_q     <= '0;
			region_length_q <= 64'd4096;
			spo_q           <= '0;
			odp_mode_q      <= 1'b0;
			odp_shift_q     <= SHIFT_W'(12);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PAGE_SIZE_MASK:    psm_q           <= pwdata;
				REG_VIRT_BASE:         virt_base_q     <= pwdata;
				REG_REGION_LENGTH:     region_length_q <= pwdata;
				REG_START_PAGE_OFFSET: spo_q           <= pwdata[OFFSET_W-1:0];
				REG_ODP_MODE:          odp_mode_q      <= pwdata[0];
				REG_ODP_PAGE_SHIFT:    odp_shift_q     <= pwdata[SHIFT_W-1:0];
				default:               ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PAGE_SIZE_MASK:    prdata = psm_q;
			REG_VIRT_BASE:         prdata = virt_base_q;
			REG_REGION_LENGTH:     prdata = region_length_q;
			REG_START_PAGE_OFFSET: prdata = 64'(spo_q);
			REG_ODP_MODE:          prdata = 64'(odp_mode_q);
			REG_ODP_PAGE_SHIFT:    prdata = 64'(odp_shift_q);
			default:               prdata = '0;
		endcase
	end

	// Stage enables: each stage moves when the one after it has room.
	assign out_en    = !res_vld_q || res.ready;
	assign s2_en     = !vld_s2 || out_en;
	assign s1_go     = vld_s1 && (!last_s1 || s2_en);
	assign seg.ready = !vld_s1 || s1_go;

	// Input register; the address is cut to the physical address width here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (seg.valid && seg.ready) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready) begin
			addr_s1 <= seg.seg_address & ADDR_MASK;
			len_s1  <= seg.seg_length;
			last_s1 <= seg.seg_last;
		end
	end

	// Seed mask: supported sizes above the highest bit of the region's bit span.
	assign first = !seen_first_q;
	assign span  = (virt_base_q + region_length_q - 64'd1) ^ virt_base_q;
	assign seed  = psm_q & ~(smear_right(span) | 64'd1);

	// Contiguity check and running state update for the segment in stage one.
	always_comb begin
		offset     = first ? (64'(spo_q) & PAGE_OFF_MASK) : '0;
		cursor_cur = first ? virt_base_q : virt_cursor_q;
		len64      = 64'(len_s1);
		end_sum    = {1'b0, run_base_q} + {1'b0, run_length_q};
		ovf        = end_sum[64] || ((end_sum[63:0] & ~ADDR_MASK) != '0);
		restart    = first || ovf || (end_sum[63:0] != addr_s1);
		diff_base  = first ? seed : diff_mask_q;
		diff_new   = diff_base;
		if (restart) begin
			diff_new = diff_base | ((addr_s1 + offset) ^ cursor_cur)
				| (first ? 64'd0 : virt_cursor_q);
		end
		run_length_next = (restart ? 64'd0 : run_length_q) + len64;
		cursor_next     = cursor_cur + len64 - offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_mask_q   <= '0;
			run_base_q    <= ALL_ONES;
			run_length_q  <= '0;
			virt_cursor_q <= '0;
			seen_first_q  <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				diff_mask_q   <= '0;
				run_base_q    <= ALL_ONES;
				run_length_q  <= '0;
				virt_cursor_q <= '0;
				seen_first_q  <= 1'b0;
			end else begin
				diff_mask_q   <= diff_new;
				run_base_q    <= restart ? addr_s1 : run_base_q;
				run_length_q  <= run_length_next;
				virt_cursor_q <= cursor_next;
				seen_first_q  <= 1'b1;
			end
		end
	end

	// Mask stage: holds the final difference mask of a region.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_en) begin
			vld_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && s1_go && last_s1) begin
			diff_s2 <= diff_new;
		end
	end

	// Page size: highest up to lowest diff bit; ODP mode: odp_size or 0.
	always_comb begin
		keep     = (diff_s2 == '0) ? ALL_ONES : (diff_s2 ^ (diff_s2 - 64'd1));
		odp_size = 64'd1 << odp_shift_q;
		if (odp_mode_q) begin
			result = ((psm_q & odp_size) != '0) ? odp_size : '0;
		end else begin
			result = top_bit(psm_q & keep);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_en) begin
			res_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && vld_s2) begin
			res_size_q <= result;
		end
	end

	assign res.valid          = res_vld_q;
	assign res.best_page_size = res_size_q;

	// A result is always a single page size or zero.
	a_result_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> $onehot0(res_size_q))
		else $error("result is not a power of two or zero");

	// A last segment returns the region tracking to its cleared state.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (!seen_first_q && diff_mask_q == '0))
		else $error("region state not cleared after last segment");

	// The first segment of a region always starts a new contiguous run.
	a_first_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !last_s1 && !seen_first_q) |=>
			(run_base_q == $past(addr_s1) && run_length_q == 64'($past(len_s1))))
		else $error("first segment did not start a new run");

	// A last segment in stage one never leaves while the mask stage is blocked.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !out_en) |-> !(s1_go && last_s1))
		else $error("mask stage overwritten while stalled");

endmodule
